>>> design/ptbt_pkg.sv
// ----------------------------------------------------------------------------
// ptbt_pkg
// Shared constants, entry layout and register codes for the token bucket table.
// ----------------------------------------------------------------------------
package ptbt_pkg;

  localparam int KEY_BITS    = 8;
  localparam int WAYS        = 4;
  localparam int NUM_BUCKETS = 1 << KEY_BITS;
  localparam int NUM_SLOTS   = NUM_BUCKETS * WAYS;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W       = $clog2(WAYS + 1);

  localparam int ADDR_W = 32;
  localparam int TOK_W  = 8;
  localparam int SUM_W  = TOK_W + 2;
  localparam int OCC_W  = 11;
  localparam int CFG_W  = 2;

  localparam logic [CFG_W-1:0] REG_FULL_LEVEL    = 2'd0;
  localparam logic [CFG_W-1:0] REG_TOKEN_DELTA   = 2'd1;
  localparam logic [CFG_W-1:0] REG_REFILL_AMOUNT = 2'd2;

  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_EPOCH = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] key;
    logic [TOK_W-1:0]  tokens;
  } entry_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             neg;
    logic             full;
  } calc_res_t;

endpackage

>>> design/per_source_token_bucket_table.sv
// ----------------------------------------------------------------------------
// per_source_token_bucket_table
// Per-source token bucket rate limiter over a hashed table of WAYS slots per
// bucket. After reset every slot of the table is cleared with input stalled.
// A check first tests the full level plus the token delta, a negative sum
// going straight to the hand-off; it then reads the bucket's slots one per
// cycle through the table's single read port, updates, and hands off the
// result. An epoch walks every slot, one per cycle, refilling live slots,
// then hands off its result. The next item is taken the cycle after the
// result is offered; a stalled earlier result holds the block in its
// hand-off step. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module per_source_token_bucket_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptbt_pkg::CFG_W-1:0]        cfg_index,
  input  logic [ptbt_pkg::TOK_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [ptbt_pkg::ADDR_W-1:0]       address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              allowed,
  output logic [ptbt_pkg::TOK_W-1:0]        tokens_left,
  output logic                              untracked,
  output logic [ptbt_pkg::OCC_W-1:0]        entries_in_use
);
  import ptbt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_PROBE, ST_DECIDE, ST_SWEEP, ST_DONE
  } state_t;

  state_t state;

  logic [TOK_W-1:0]  full_level;
  logic [TOK_W-1:0]  token_delta;
  logic [TOK_W-1:0]  refill_amount;
  logic [OCC_W-1:0]  occupancy;

  logic [ADDR_W-1:0] addr;
  logic [SLOT_W-1:0] base;
  logic [SLOT_W-1:0] clr_idx;
  logic [CNT_W-1:0]  cnt;
  logic [TOK_W-1:0]  start_tok;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [TOK_W-1:0]  hit_tok;
  logic              free_found;
  logic [WAY_W-1:0]  free_way;
  logic [SLOT_W-1:0] sw_rd;
  logic              sw_rd_more;
  logic              sw_pend;
  logic [SLOT_W-1:0] sw_wr;

  logic              res_allowed;
  logic [TOK_W-1:0]  res_left;
  logic              res_untracked;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  entry_t            ram_rdata;

  logic [TOK_W-1:0]  calc_a;
  logic [SUM_W-1:0]  calc_b;
  calc_res_t         calc;

  logic [SUM_W-1:0]  delta_ext;
  logic [WAY_W-1:0]  cmp_way;
  logic              delta_neg;

  assign delta_ext = {{(SUM_W-TOK_W){token_delta[TOK_W-1]}}, token_delta};
  assign delta_neg = token_delta[TOK_W-1];
  assign cmp_way   = WAY_W'(cnt - CNT_W'(1));
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  ptbt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptbt_calc u_calc (
    .a   (calc_a),
    .b   (calc_b),
    .lim (full_level),
    .res (calc)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    ram_raddr = base + SLOT_W'(cnt[WAY_W-1:0]);
    calc_a    = full_level;
    calc_b    = delta_ext;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_DECIDE: begin
        calc_a = hit_tok;
        if (hit) begin
          ram_waddr = base + SLOT_W'(hit_way);
          ram_we    = !calc.neg;
          ram_wdata = {!calc.full, addr, calc.sum[TOK_W-1:0]};
        end else begin
          ram_waddr = base + SLOT_W'(free_way);
          ram_we    = delta_neg && free_found;
          ram_wdata = {1'b1, addr, start_tok};
        end
      end
      ST_SWEEP: begin
        ram_raddr = sw_rd;
        ram_waddr = sw_wr;
        calc_a    = ram_rdata.tokens;
        calc_b    = {{(SUM_W-TOK_W){1'b0}}, refill_amount};
        ram_we    = sw_pend && ram_rdata.valid;
        ram_wdata = {!calc.full, ram_rdata.key, calc.sum[TOK_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      occupancy     <= '0;
      full_level    <= 8'd8;
      token_delta   <= 8'hFF;
      refill_amount <= 8'd1;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_FULL_LEVEL:    full_level    <= cfg_data;
          REG_TOKEN_DELTA:   token_delta   <= cfg_data;
          REG_REFILL_AMOUNT: refill_amount <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SLOT_W'(1);
          if (clr_idx == SLOT_W'(NUM_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            addr          <= address;
            base          <= SLOT_W'(address[ADDR_W-1 -: KEY_BITS]) * SLOT_W'(WAYS);
            res_allowed   <= 1'b0;
            res_left      <= '0;
            res_untracked <= 1'b0;
            cnt           <= '0;
            hit           <= 1'b0;
            free_found    <= 1'b0;
            sw_rd         <= '0;
            sw_rd_more    <= 1'b1;
            sw_pend       <= 1'b0;
            state         <= (command == CMD_EPOCH) ? ST_SWEEP : ST_START;
          end
        end
        ST_START: begin
          start_tok <= calc.sum[TOK_W-1:0];
          state     <= calc.neg ? ST_DONE : ST_PROBE;
        end
        ST_PROBE: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt != '0) begin
            if (ram_rdata.valid) begin
              if (!hit && ram_rdata.key == addr) begin
                hit     <= 1'b1;
                hit_way <= cmp_way;
                hit_tok <= ram_rdata.tokens;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_way   <= cmp_way;
            end
          end
          if (cnt == CNT_W'(WAYS)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_allowed <= 1'b1;
          if (hit) begin
            if (calc.neg) begin
              res_allowed <= 1'b0;
            end else if (calc.full) begin
              occupancy <= occupancy - OCC_W'(1);
              res_left  <= full_level;
            end else begin
              res_left <= calc.sum[TOK_W-1:0];
            end
          end else if (!delta_neg) begin
            res_left <= full_level;
          end else begin
            res_left <= start_tok;
            if (free_found) begin
              occupancy <= occupancy + OCC_W'(1);
            end else begin
              res_untracked <= 1'b1;
            end
          end
          state <= ST_DONE;
        end
        ST_SWEEP: begin
          sw_pend <= sw_rd_more;
          sw_wr   <= sw_rd;
          sw_rd   <= sw_rd + SLOT_W'(1);
          if (sw_rd == SLOT_W'(NUM_SLOTS - 1)) begin
            sw_rd_more <= 1'b0;
          end
          if (sw_pend && ram_rdata.valid && calc.full) begin
            occupancy <= occupancy - OCC_W'(1);
          end
          if (!sw_rd_more) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            allowed        <= res_allowed;
            tokens_left    <= res_left;
            untracked      <= res_untracked;
            entries_in_use <= occupancy;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken but block not busy");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !ram_we)
    else $error("table written while idle");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (occupancy == $past(occupancy) ||
                     occupancy == $past(occupancy) + OCC_W'(1) ||
                     occupancy == $past(occupancy) - OCC_W'(1)))
    else $error("occupancy moved by more than one");
`endif

endmodule

>>> design/ptbt_ram.sv
// ----------------------------------------------------------------------------
// ptbt_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ptbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/ptbt_calc.sv
// ----------------------------------------------------------------------------
// ptbt_calc
// Shared add and compare unit: token count plus signed change, checked
// against zero and against the full level.
// ----------------------------------------------------------------------------
module ptbt_calc (
  input  logic [ptbt_pkg::TOK_W-1:0] a,
  input  logic [ptbt_pkg::SUM_W-1:0] b,
  input  logic [ptbt_pkg::TOK_W-1:0] lim,
  output ptbt_pkg::calc_res_t        res
);
  import ptbt_pkg::*;

  logic [SUM_W-1:0] sum;

  assign sum      = {{(SUM_W-TOK_W){1'b0}}, a} + b;
  assign res.sum  = sum;
  assign res.neg  = sum[SUM_W-1];
  assign res.full = !sum[SUM_W-1] && (sum >= {{(SUM_W-TOK_W){1'b0}}, lim});

endmodule

>>> tb/sv/tb_per_source_token_bucket_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_source_token_bucket_table
// Drives check and epoch commands through the token bucket table with random
// idling on both sides and compares every result transfer against a local
// model of the slot table and registers. Registers change only while idle.
// ----------------------------------------------------------------------------
module tb_per_source_token_bucket_table;
  import ptbt_pkg::*;

  typedef struct packed {
    logic             allowed;
    logic [TOK_W-1:0] tokens_left;
    logic             untracked;
    logic [OCC_W-1:0] entries_in_use;
  } verdict_t;

  typedef struct {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic              known;
    verdict_t          res;
  } row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_W-1:0] cfg_index;
  logic [TOK_W-1:0] cfg_data;
  logic in_valid, in_stall, command;
  logic [ADDR_W-1:0] address;
  logic out_valid, out_stall, allowed, untracked;
  logic [TOK_W-1:0] tokens_left;
  logic [OCC_W-1:0] entries_in_use;

  per_source_token_bucket_table dut (.*);

  logic [ADDR_W-1:0] slot_key    [NUM_SLOTS];
  logic [TOK_W-1:0]  slot_tokens [NUM_SLOTS];
  logic              slot_live   [NUM_SLOTS];
  int unsigned       live_count;
  int unsigned       full_level;
  int                charge;
  int unsigned       refill;

  verdict_t pending_verdicts[$];
  int  mismatches;
  bit  quiet_phase;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_per_source_token_bucket_table: FAIL");
    $finish;
  end

  function automatic verdict_t rate_limit(logic cmd, logic [ADDR_W-1:0] addr);
    verdict_t v;
    int base, hit, spare, n, start;
    v = '{1'b0, '0, 1'b0, '0};
    if (cmd == CMD_EPOCH) begin
      for (int i = 0; i < NUM_SLOTS; i++)
        if (slot_live[i]) begin
          if (int'(slot_tokens[i]) + refill >= full_level) begin
            slot_live[i] = 0;
            live_count--;
          end else slot_tokens[i] = slot_tokens[i] + refill;
        end
    end else begin
      start = int'(full_level) + charge;
      if (start >= 0) begin
        base = int'(addr >> (ADDR_W - KEY_BITS)) * WAYS;
        hit = -1;
        spare = -1;
        for (int w = 0; w < WAYS; w++) begin
          if (slot_live[base+w]) begin
            if (slot_key[base+w] == addr && hit < 0) hit = base + w;
          end else if (spare < 0) spare = base + w;
        end
        if (hit >= 0) begin
          n = int'(slot_tokens[hit]) + charge;
          if (n >= 0) begin
            v.allowed = 1;
            if (n >= int'(full_level)) begin
              slot_live[hit] = 0;
              live_count--;
              v.tokens_left = full_level;
            end else begin
              slot_tokens[hit] = n;
              v.tokens_left = n;
            end
          end
        end else if (charge >= 0) begin
          v.allowed = 1;
          v.tokens_left = full_level;
        end else begin
          v.allowed = 1;
          v.tokens_left = start;
          if (spare < 0) v.untracked = 1;
          else begin
            slot_live[spare] = 1;
            slot_key[spare] = addr;
            slot_tokens[spare] = start;
            live_count++;
          end
        end
      end
    end
    v.entries_in_use = live_count;
    return v;
  endfunction

  task automatic write_reg(logic [CFG_W-1:0] idx, logic [TOK_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_FULL_LEVEL:    full_level = val;
      REG_TOKEN_DELTA:   charge = $signed(val);
      REG_REFILL_AMOUNT: refill = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(logic cmd, logic [ADDR_W-1:0] addr, bit known, verdict_t typed);
    verdict_t v;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    command  <= cmd;
    address  <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = rate_limit(cmd, addr);
    if (known && v != typed)
      $display("directed row disagrees with model: addr %h", addr);
    pending_verdicts.push_back(known ? typed : v);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 0;
    guard = 0;
    while (pending_verdicts.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (!quiet_phase && $urandom_range(0, 5) == 0) out_stall <= 1;
    else if (out_stall && !quiet_phase && $urandom_range(0, 2) != 0) out_stall <= 1;
    else out_stall <= 0;
  end

  always @(posedge clk) begin
    verdict_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        e = pending_verdicts.pop_front();
        if (allowed !== e.allowed || tokens_left !== e.tokens_left ||
            untracked !== e.untracked || entries_in_use !== e.entries_in_use) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp a%0d t%0d u%0d n%0d got a%0d t%0d u%0d n%0d",
                     e.allowed, e.tokens_left, e.untracked, e.entries_in_use,
                     allowed, tokens_left, untracked, entries_in_use);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    logic [ADDR_W-1:0] pool[16];
    logic [ADDR_W-1:0] a;
    int guard;
    mismatches = 0;
    quiet_phase = 0;
    rst = 1;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; command = CMD_CHECK; address = '0;
    for (int i = 0; i < NUM_SLOTS; i++) slot_live[i] = 0;
    live_count = 0; full_level = 8; charge = -1; refill = 1;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: known rows typed in, others from the model
    rows.push_back('{CMD_EPOCH, 32'h0,        1, '{0, 0, 0, 0}});
    rows.push_back('{CMD_CHECK, 32'h00000000, 1, '{1, 7, 0, 1}});
    rows.push_back('{CMD_CHECK, 32'hFFFFFFFF, 1, '{1, 7, 0, 2}});
    rows.push_back('{CMD_CHECK, 32'h00000000, 1, '{1, 6, 0, 2}});
    for (int i = 0; i < 5; i++)
      rows.push_back('{CMD_CHECK, 32'hAB000000 | i, 0, '{0, 0, 0, 0}});
    for (int i = 0; i < 8; i++)
      rows.push_back('{CMD_CHECK, 32'h00000000, 0, '{0, 0, 0, 0}});
    rows.push_back('{CMD_EPOCH, 32'hFFFFFFFF, 0, '{0, 0, 0, 0}});
    rows.push_back('{CMD_CHECK, 32'h55555555, 0, '{0, 0, 0, 0}});
    rows.push_back('{CMD_CHECK, 32'hAAAAAAAA, 0, '{0, 0, 0, 0}});
    foreach (rows[i]) send_item(rows[i].cmd, rows[i].addr, rows[i].known, rows[i].res);
    drain();

    // register settings: extremes and mixes
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin write_reg(REG_FULL_LEVEL, 8'd0);   write_reg(REG_TOKEN_DELTA, 8'h80); end
        1: begin write_reg(REG_FULL_LEVEL, 8'd255); write_reg(REG_TOKEN_DELTA, 8'h7F);
                 write_reg(REG_REFILL_AMOUNT, 8'd0); end
        2: begin write_reg(REG_TOKEN_DELTA, 8'h80); write_reg(REG_REFILL_AMOUNT, 8'd255); end
        3: begin write_reg(REG_FULL_LEVEL, 8'd3);   write_reg(REG_TOKEN_DELTA, 8'hFF);
                 write_reg(REG_REFILL_AMOUNT, 8'd1); end
        4: write_reg(REG_TOKEN_DELTA, 8'd0);
        5: begin write_reg(REG_FULL_LEVEL, 8'd255); write_reg(REG_TOKEN_DELTA, 8'hF1);
                 write_reg(REG_REFILL_AMOUNT, 8'd15); end
        6: write_reg(REG_FULL_LEVEL, 8'd10);
        default: begin
          write_reg(REG_FULL_LEVEL, $urandom_range(0, 255));
          write_reg(REG_TOKEN_DELTA, $urandom_range(0, 255));
          write_reg(REG_REFILL_AMOUNT, $urandom_range(0, 255));
        end
      endcase
      if (phase == 9) quiet_phase = 1;
      for (int k = 0; k < 16; k++)
        pool[k] = {$urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255)) : 8'(k[0]), 24'($urandom)};
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 24) == 0) send_item(CMD_EPOCH, $urandom, 0, '{0, 0, 0, 0});
        else begin
          a = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 15)];
          send_item(CMD_CHECK, a, 0, '{0, 0, 0, 0});
        end
      end
      drain();
    end

    guard = 0;
    while (pending_verdicts.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("tb_per_source_token_bucket_table: PASS");
    else
      $display("tb_per_source_token_bucket_table: FAIL");
    $finish;
  end
endmodule

>>> per_source_token_bucket_table.f
design/ptbt_pkg.sv
design/ptbt_ram.sv
design/ptbt_calc.sv
design/per_source_token_bucket_table.sv
tb/sv/tb_per_source_token_bucket_table.sv
